// ===== hdl/tile_cache_pixel_locator_macros.svh =====
// Assertion macros shared by the tile cache pixel locator RTL.
// Included by the modules that carry concurrent checks.
`ifndef TILE_CACHE_PIXEL_LOCATOR_MACROS_SVH
`define TILE_CACHE_PIXEL_LOCATOR_MACROS_SVH
`ifndef SYNTH
`define TCPL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCPL_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCPL_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCPL_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/tcpl_pkg.sv =====
// Package for the tile cache pixel locator: widths, codes, reset values.
// No dependencies.
package tcpl_pkg;
    localparam int MaxWays = 16;
    localparam int WayW = $clog2(MaxWays);
    localparam int EntryW = 1 + 32 + 32;
    localparam int DivW = 16;

    localparam logic [15:0] RstWidth  = 16'd1024;
    localparam logic [15:0] RstHeight = 16'd1024;
    localparam logic [12:0] RstTile   = 13'd256;
    localparam logic [15:0] RstAcross = 16'd4;
    localparam logic [4:0]  RstWays   = 5'd4;

    localparam logic [2:0] RegWidth  = 3'd0;
    localparam logic [2:0] RegHeight = 3'd1;
    localparam logic [2:0] RegTile   = 3'd2;
    localparam logic [2:0] RegAcross = 3'd3;
    localparam logic [2:0] RegWays   = 3'd4;

    typedef struct packed {
        logic        oob;
        logic        hit;
        logic [3:0]  slot;
        logic [31:0] tile_number;
        logic [23:0] offset;
        logic        ev_valid;
        logic [31:0] ev_tile;
    } t_result;
endpackage

// ===== hdl/tcpl_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module tcpl_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/tcpl_divider.sv =====
// Restoring divider, one quotient bit per cycle, 16-bit dividend and divisor.
// Depends on tcpl_pkg.
module tcpl_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tcpl_pkg::DivW-1:0] i_dividend,
    input  logic [tcpl_pkg::DivW-1:0] i_divisor,
    output logic                      o_done,
    output logic [tcpl_pkg::DivW-1:0] o_quot,
    output logic [tcpl_pkg::DivW-1:0] o_rem
);
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [15:0] r_q;
    logic [16:0] r_r;
    logic [15:0] r_d;
    logic [16:0] n_shift;
    logic [17:0] n_diff;

    always_comb begin
        n_shift = {r_r[15:0], r_q[15]};
        n_diff  = {1'b0, n_shift} - {2'b00, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            if (!n_diff[17]) begin
                r_r <= n_diff[16:0];
                r_q <= {r_q[14:0], 1'b1};
            end else begin
                r_r <= n_shift;
                r_q <= {r_q[14:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r[15:0];
endmodule

// ===== hdl/tile_cache_pixel_locator.sv =====
// Top level of the tile cache pixel locator: APB registers, stream ports,
// control sequencer, tag/stamp RAM. Depends on tcpl_pkg, tcpl_ram, tcpl_divider.
//
// Channel   Direction  Contents (low bits first)
// s_axis    in         tdata: pixel_x[15:0], pixel_y[31:16]
// m_axis    out        tdata: hit, slot, tile_number, offset_in_tile, evicted_valid,
//                      evicted_tile (94 bits padded to 96); tuser: out_of_bounds
// apb       in/out     registers at byte addresses 0,4,8,12,16
//
// An in-bounds item goes through four divides (x and y by the tile size, tile column
// by the column count, width minus one by the tile size), the StMul and StOff setup
// states, a read and a check per way in the hit sweep and, on a miss, in the victim
// sweep, and a write-back state before its result is valid.
// An out-of-bounds item has its result valid the cycle after acceptance.
// Reset empties every way by valid bits. One item is in work at a time; the next is
// accepted the cycle after the result transaction, and the result holds while m_axis stalls.
`include "tile_cache_pixel_locator_macros.svh"
module tile_cache_pixel_locator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pixel_x[15:0], pixel_y[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // hit[0], slot[4:1], tile_number[36:5], offset_in_tile[60:37],
    // evicted_valid[61], evicted_tile[93:62], zeros[95:94]
    output logic [95:0] m_axis_tdata,
    output logic        m_axis_tuser,   // out_of_bounds[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [3:0] StIdle    = 4'd0;
    localparam logic [3:0] StDivX    = 4'd1;
    localparam logic [3:0] StDivY    = 4'd2;
    localparam logic [3:0] StDivCol  = 4'd3;
    localparam logic [3:0] StDivEdge = 4'd4;
    localparam logic [3:0] StMul     = 4'd5;
    localparam logic [3:0] StOff     = 4'd6;
    localparam logic [3:0] StHitRd   = 4'd7;
    localparam logic [3:0] StHitChk  = 4'd8;
    localparam logic [3:0] StVicRd   = 4'd9;
    localparam logic [3:0] StVicChk  = 4'd10;
    localparam logic [3:0] StWrite   = 4'd11;

    logic [15:0] r_width, r_height, r_across;
    logic [12:0] r_tile;
    logic [4:0]  r_ways;

    logic        wr_en;
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= tcpl_pkg::RstWidth;
            r_height <= tcpl_pkg::RstHeight;
            r_tile   <= tcpl_pkg::RstTile;
            r_across <= tcpl_pkg::RstAcross;
            r_ways   <= tcpl_pkg::RstWays;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                tcpl_pkg::RegWidth:  r_width  <= pwdata[15:0];
                tcpl_pkg::RegHeight: r_height <= pwdata[15:0];
                tcpl_pkg::RegTile:   r_tile   <= pwdata[12:0];
                tcpl_pkg::RegAcross: r_across <= pwdata[15:0];
                tcpl_pkg::RegWays:   r_ways   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            tcpl_pkg::RegWidth:  prdata = {16'd0, r_width};
            tcpl_pkg::RegHeight: prdata = {16'd0, r_height};
            tcpl_pkg::RegTile:   prdata = {19'd0, r_tile};
            tcpl_pkg::RegAcross: prdata = {16'd0, r_across};
            tcpl_pkg::RegWays:   prdata = {27'd0, r_ways};
            default:             prdata = '0;
        endcase
    end

    // Effective configuration.
    logic [12:0] ts;
    logic [15:0] wide;
    logic [4:0]  ways;
    assign ts   = (r_tile == 13'd0) ? 13'd1 : r_tile;
    assign wide = (r_across == 16'd0) ? 16'd1 : r_across;
    assign ways = (r_ways == 5'd0) ? 5'd1 :
                  (r_ways > 5'(tcpl_pkg::MaxWays)) ? 5'(tcpl_pkg::MaxWays) : r_ways;

    logic [3:0]  r_state;
    logic [15:0] r_y, r_tilex, r_tiley;
    logic [12:0] r_lx, r_ly;
    logic [31:0] r_tn, r_clock, r_minstamp;
    logic [12:0] r_twidth;
    logic        r_lastcol;
    logic [4:0]  r_idx;
    logic        r_hit;
    logic [3:0]  r_found;
    logic        r_evv;
    logic [31:0] r_evt;
    logic [tcpl_pkg::MaxWays-1:0] r_valid;
    tcpl_pkg::t_result r_res;
    logic        r_ovalid;
    logic [23:0] r_off;

    // One divider serves all four divides of an item, one after the other.
    logic        div_start, div_done;
    logic [15:0] div_q, div_dd, div_ds, div_r;
    always_comb begin
        div_dd = r_y;
        div_ds = {3'd0, ts};
        unique case (r_state)
            StIdle:   div_dd = s_axis_tdata[15:0];
            StDivY: begin
                div_dd = r_tilex;
                div_ds = wide;
            end
            StDivCol: div_dd = r_width - 16'd1;
            default: ;
        endcase
    end

    tcpl_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(div_dd), .i_divisor(div_ds),
        .o_done(div_done), .o_quot(div_q), .o_rem(div_r)
    );

    // Tag and stamp memory: {tag, stamp}; validity lives in r_valid.
    logic        ram_we;
    logic [3:0]  ram_waddr, ram_raddr;
    logic [63:0] ram_wdata, ram_rdata;
    tcpl_ram #(.Width(64), .Depth(tcpl_pkg::MaxWays)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );
    assign ram_raddr = r_idx[3:0];

    logic in_acc, out_acc, oob;
    assign s_axis_tready = (r_state == StIdle) && !r_ovalid;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign oob = (s_axis_tdata[15:0] >= r_width) || (s_axis_tdata[31:16] >= r_height);
    assign div_start = (in_acc && !oob) ||
                       (div_done && (r_state == StDivX || r_state == StDivY ||
                                     r_state == StDivCol));

    // The tile number never exceeds 32 bits, so (tile_number - 1) mod the column
    // count is the tile column mod the column count.
    logic [31:0] mul_tn;
    assign mul_tn = 32'(r_tiley) * 32'(wide) + 32'(r_tilex) + 32'd1;
    logic [25:0] off_full;
    assign off_full = 26'(r_ly) * 26'(r_twidth) + 26'(r_lx);

    always_comb begin
        ram_we    = (r_state == StWrite) && !r_hit;
        ram_waddr = r_found;
        ram_wdata = {r_tn, r_clock + 32'd1};
        if (r_state == StWrite && r_hit) begin
            ram_we    = 1'b1;
            ram_wdata = {r_tn, r_clock};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_ovalid <= 1'b0;
            r_valid  <= '0;
            r_clock  <= '0;
        end else begin
            if (out_acc) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                StIdle: begin
                    if (in_acc) begin
                        r_y <= s_axis_tdata[31:16];
                        if (oob) begin
                            r_res.oob         <= 1'b1;
                            r_res.hit         <= 1'b0;
                            r_res.slot        <= '0;
                            r_res.tile_number <= '0;
                            r_res.offset      <= '0;
                            r_res.ev_valid    <= 1'b0;
                            r_res.ev_tile     <= '0;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_state <= StDivX;
                        end
                    end
                end
                StDivX: begin
                    if (div_done) begin
                        r_tilex <= div_q;
                        r_lx    <= div_r[12:0];
                        r_state <= StDivY;
                    end
                end
                StDivY: begin
                    if (div_done) begin
                        r_tiley <= div_q;
                        r_ly    <= div_r[12:0];
                        r_state <= StDivCol;
                    end
                end
                StDivCol: begin
                    if (div_done) begin
                        r_lastcol <= (div_r == wide - 16'd1);
                        r_state   <= StDivEdge;
                    end
                end
                StDivEdge: begin
                    if (div_done) begin
                        // The rightmost column is narrowed to the remainder width.
                        r_twidth <= r_lastcol ? div_r[12:0] + 13'd1 : ts;
                        r_state  <= StMul;
                    end
                end
                StMul: begin
                    r_tn    <= mul_tn;
                    r_state <= StOff;
                end
                StOff: begin
                    r_off   <= off_full[23:0];
                    r_idx   <= '0;
                    r_hit   <= 1'b0;
                    r_state <= StHitRd;
                end
                StHitRd: begin
                    r_state <= StHitChk;
                end
                StHitChk: begin
                    if (r_valid[r_idx[3:0]] && ram_rdata[63:32] == r_tn) begin
                        r_hit   <= 1'b1;
                        r_found <= r_idx[3:0];
                        r_state <= StWrite;
                    end else if (r_idx + 5'd1 >= ways) begin
                        r_idx   <= '0;
                        r_evv   <= 1'b0;
                        r_state <= StVicRd;
                    end else begin
                        r_idx   <= r_idx + 5'd1;
                        r_state <= StHitRd;
                    end
                end
                StVicRd: begin
                    r_state <= StVicChk;
                end
                StVicChk: begin
                    if (!r_valid[r_idx[3:0]]) begin
                        r_found <= r_idx[3:0];
                        r_evv   <= 1'b0;
                        r_state <= StWrite;
                    end else begin
                        if (r_idx == 5'd0 || ram_rdata[31:0] < r_minstamp) begin
                            r_minstamp <= ram_rdata[31:0];
                            r_found    <= r_idx[3:0];
                            r_evt      <= ram_rdata[63:32];
                        end
                        if (r_idx + 5'd1 >= ways) begin
                            r_evv   <= 1'b1;
                            r_state <= StWrite;
                        end else begin
                            r_idx   <= r_idx + 5'd1;
                            r_state <= StVicRd;
                        end
                    end
                end
                StWrite: begin
                    r_valid[r_found] <= 1'b1;
                    r_clock <= r_clock + 32'd1;
                    r_res.oob         <= 1'b0;
                    r_res.hit         <= r_hit;
                    r_res.slot        <= r_found;
                    r_res.tile_number <= r_tn;
                    r_res.offset      <= r_off;
                    r_res.ev_valid    <= !r_hit && r_evv;
                    r_res.ev_tile     <= (!r_hit && r_evv) ? r_evt : 32'd0;
                    r_ovalid <= 1'b1;
                    r_state  <= StIdle;
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_res.oob;
    assign m_axis_tdata  = {2'b00, r_res.ev_tile, r_res.ev_valid, r_res.offset,
                            r_res.tile_number, r_res.slot, r_res.hit};

    `TCPL_ASSERT(a_busy_no_ready, i_clk, i_rst_n,
                 (r_state != StIdle) |-> !s_axis_tready, "ready while busy")
    `TCPL_ASSERT(a_oob_zero, i_clk, i_rst_n,
                 (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 96'd0),
                 "oob result not zero")
    `TCPL_ASSERT(a_write_valid, i_clk, i_rst_n,
                 (r_state == StWrite) |=> r_valid[$past(r_found)], "written way not valid")
    `TCPL_ASSERT(a_hit_noevict, i_clk, i_rst_n,
                 (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tdata[61], "hit with eviction")
endmodule
